>>> src/smalu_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine ALU package
// Shared types, codes and constants for the evaluation stack and its ALU.
// ----------------------------------------------------------------------------
package smalu_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int OP_WIDTH      = 5;
   localparam int DEPTH_DEFAULT = 64;

   localparam logic [OP_WIDTH-1:0] OP_PUSH  = 5'd0;
   localparam logic [OP_WIDTH-1:0] OP_POP   = 5'd1;
   localparam logic [OP_WIDTH-1:0] OP_COPY  = 5'd2;
   localparam logic [OP_WIDTH-1:0] OP_PRINT = 5'd3;
   localparam logic [OP_WIDTH-1:0] OP_ADD   = 5'd4;
   localparam logic [OP_WIDTH-1:0] OP_SUB   = 5'd5;
   localparam logic [OP_WIDTH-1:0] OP_MUL   = 5'd6;
   localparam logic [OP_WIDTH-1:0] OP_QUOT  = 5'd7;
   localparam logic [OP_WIDTH-1:0] OP_REM   = 5'd8;
   localparam logic [OP_WIDTH-1:0] OP_AND   = 5'd9;
   localparam logic [OP_WIDTH-1:0] OP_OR    = 5'd10;
   localparam logic [OP_WIDTH-1:0] OP_NOT   = 5'd11;
   localparam logic [OP_WIDTH-1:0] OP_NE    = 5'd12;
   localparam logic [OP_WIDTH-1:0] OP_LE    = 5'd13;
   localparam logic [OP_WIDTH-1:0] OP_GE    = 5'd14;
   localparam logic [OP_WIDTH-1:0] OP_LT    = 5'd15;
   localparam logic [OP_WIDTH-1:0] OP_GT    = 5'd16;
   localparam logic [OP_WIDTH-1:0] OP_EQ    = 5'd17;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIV0  = 2'd3
   } status_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]          op;
      logic signed [DATA_WIDTH-1:0] imm;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] top_value;
      logic                         top_valid;
      status_type                   status;
   } rsp_type;

   typedef enum logic [2:0] {
      SO_HOLD,
      SO_PUSH,
      SO_POP1,
      SO_POP2,
      SO_REPL,
      SO_BIN
   } stack_op_type;

   typedef enum logic [1:0] {
      CM_HOLD,
      CM_PREV,
      CM_NEXT,
      CM_NEXT2
   } cell_mode_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_DIV,
      FSM_COMMIT
   } fsm_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage

>>> src/smalu_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// One word of the stack; it shifts towards or away from the top on command.
// ----------------------------------------------------------------------------
module smalu_cell
   import smalu_pkg::*;
(
   input  logic                  clock,
   input  cell_mode_type         mode,
   input  logic [DATA_WIDTH-1:0] prev_word,
   input  logic [DATA_WIDTH-1:0] next_word,
   input  logic [DATA_WIDTH-1:0] next2_word,
   output logic [DATA_WIDTH-1:0] word,
   output logic [DATA_WIDTH-1:0] word_next
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   always_comb begin
      unique case (mode)
         CM_PREV:  word_in = prev_word;
         CM_NEXT:  word_in = next_word;
         CM_NEXT2: word_in = next2_word;
         default:  word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word      = word_ff;
   assign word_next = word_in;

endmodule

>>> src/smalu_div.sv
// ----------------------------------------------------------------------------
// Magnitude divider
// Restoring unsigned divider giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smalu_div
   import smalu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output div_ctrl_type          ctrl,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);

   localparam int STEP_W = $clog2(DATA_WIDTH);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DATA_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign quotient   = quo_ff;
   assign remainder  = rem_ff;

endmodule

>>> src/stack_machine_alu.sv
// ----------------------------------------------------------------------------
// Stack machine ALU
// Evaluation stack held in a row of shifting cells, with a sequenced ALU.
// ----------------------------------------------------------------------------
// A request passes from the idle state through EXEC to COMMIT, with a DIV state between them for
// quotient and remainder, where the divider gives one quotient bit per cycle. COMMIT waits while an
// earlier response is stalled, and a new request is taken only in the idle state.
// Reset clears the word count and the control state; the stack words are not reset.
module stack_machine_alu
   import smalu_pkg::*;
#(
   parameter int STACK_DEPTH = DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   fsm_type                      state_ff, state_in;
   logic [OP_WIDTH-1:0]          op_ff, op_in;
   logic [DATA_WIDTH-1:0]        imm_ff, imm_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   stack_op_type                 sop_ff, sop_in;
   status_type                   status_ff, status_in;
   logic [DATA_WIDTH-1:0]        res_ff, res_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   logic [DATA_WIDTH-1:0]        word [STACK_DEPTH+2];
   logic [DATA_WIDTH-1:0]        top_next;
   cell_mode_type                mode [STACK_DEPTH];
   cell_mode_type                top_mode, rest_mode;

   logic                         div_start;
   div_ctrl_type                 div_ctrl;
   logic [DATA_WIDTH-1:0]        div_quo, div_rem;
   logic [DATA_WIDTH-1:0]        a_w, b_w, mag_a, mag_b, mul_w;
   logic                         commit;

   assign b_w   = word[0];
   assign a_w   = word[1];
   assign mag_a = a_w[DATA_WIDTH-1] ? (~a_w + 1'b1) : a_w;
   assign mag_b = b_w[DATA_WIDTH-1] ? (~b_w + 1'b1) : b_w;
   assign mul_w = a_w * b_w;

   assign word[STACK_DEPTH]     = '0;
   assign word[STACK_DEPTH + 1] = '0;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_w;
      logic [DATA_WIDTH-1:0] next_w;
      if (i == 0) begin : g_top
         assign prev_w  = res_ff;
         assign mode[i] = top_mode;
      end else begin : g_rest
         assign prev_w  = word[i-1];
         assign mode[i] = rest_mode;
      end
      if (i == 0) begin : g_top_next
         assign top_next = next_w;
      end
      smalu_cell u_cell (
         .clock      (clock),
         .mode       (mode[i]),
         .prev_word  (prev_w),
         .next_word  (word[i+1]),
         .next2_word (word[i+2]),
         .word       (word[i]),
         .word_next  (next_w)
      );
   end

   smalu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .ctrl      (div_ctrl),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign commit = (state_ff == FSM_COMMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      top_mode  = CM_HOLD;
      rest_mode = CM_HOLD;
      count_in  = count_ff;
      if (commit) begin
         unique case (sop_ff)
            SO_PUSH: begin
               top_mode  = CM_PREV;
               rest_mode = CM_PREV;
               count_in  = count_ff + 1'b1;
            end
            SO_POP1: begin
               top_mode  = CM_NEXT;
               rest_mode = CM_NEXT;
               count_in  = count_ff - 1'b1;
            end
            SO_POP2: begin
               top_mode  = CM_NEXT2;
               rest_mode = CM_NEXT2;
               count_in  = count_ff - CNT_W'(2);
            end
            SO_REPL: begin
               top_mode  = CM_PREV;
            end
            SO_BIN: begin
               top_mode  = CM_PREV;
               rest_mode = CM_NEXT;
               count_in  = count_ff - 1'b1;
            end
            default: begin
               top_mode  = CM_HOLD;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      imm_in       = imm_ff;
      sop_in       = sop_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = (state_ff == FSM_IDLE);
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.op;
               imm_in   = req_data.imm;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            sop_in    = SO_HOLD;
            status_in = ST_OK;
            res_in    = '0;
            state_in  = FSM_COMMIT;
            priority if (op_ff == OP_PUSH) begin
               if (count_ff >= CNT_FULL) begin
                  status_in = ST_OVER;
               end else begin
                  sop_in = SO_PUSH;
                  res_in = imm_ff;
               end
            end else if (op_ff == OP_POP) begin
               if (count_ff == '0) status_in = ST_UNDER;
               else sop_in = SO_POP1;
            end else if (op_ff == OP_COPY) begin
               if (count_ff == '0) begin
                  status_in = ST_UNDER;
               end else if (count_ff >= CNT_FULL) begin
                  status_in = ST_OVER;
               end else begin
                  sop_in = SO_PUSH;
                  res_in = b_w;
               end
            end else if (op_ff == OP_PRINT) begin
               if (count_ff == '0) status_in = ST_UNDER;
            end else if (op_ff == OP_NOT) begin
               if (count_ff == '0) begin
                  status_in = ST_UNDER;
               end else if (b_w == DATA_WIDTH'(0)) begin
                  sop_in = SO_REPL;
                  res_in = DATA_WIDTH'(1);
               end else if (b_w == DATA_WIDTH'(1)) begin
                  sop_in = SO_REPL;
                  res_in = '0;
               end else begin
                  sop_in = SO_POP1;
               end
            end else if (op_ff >= OP_ADD && op_ff <= OP_EQ) begin
               if (count_ff < CNT_W'(2)) begin
                  status_in = ST_UNDER;
               end else if ((op_ff == OP_QUOT || op_ff == OP_REM) && b_w == '0) begin
                  sop_in    = SO_POP2;
                  status_in = ST_DIV0;
               end else begin
                  sop_in = SO_BIN;
                  unique case (op_ff)
                     OP_ADD: res_in = a_w + b_w;
                     OP_SUB: res_in = a_w - b_w;
                     OP_MUL: res_in = mul_w;
                     OP_QUOT, OP_REM: begin
                        div_start = 1'b1;
                        state_in  = FSM_DIV;
                     end
                     OP_AND: res_in = DATA_WIDTH'(a_w == 1 && b_w == 1);
                     OP_OR:  res_in = DATA_WIDTH'(a_w == 1 || b_w == 1);
                     OP_NE:  res_in = DATA_WIDTH'(a_w != b_w);
                     OP_LE:  res_in = DATA_WIDTH'(!($signed(b_w) < $signed(a_w)));
                     OP_GE:  res_in = DATA_WIDTH'(!($signed(a_w) < $signed(b_w)));
                     OP_LT:  res_in = DATA_WIDTH'($signed(a_w) < $signed(b_w));
                     OP_GT:  res_in = DATA_WIDTH'($signed(b_w) < $signed(a_w));
                     default: res_in = DATA_WIDTH'(a_w == b_w);
                  endcase
               end
            end else begin
               sop_in = SO_HOLD;
            end
         end
         FSM_DIV: begin
            if (div_ctrl.done) begin
               state_in = FSM_COMMIT;
               if (op_ff == OP_QUOT) begin
                  res_in = (a_w[DATA_WIDTH-1] ^ b_w[DATA_WIDTH-1]) ?
                           (~div_quo + 1'b1) : div_quo;
               end else begin
                  res_in = a_w[DATA_WIDTH-1] ? (~div_rem + 1'b1) : div_rem;
               end
            end
         end
         FSM_COMMIT: begin
            if (commit) begin
               state_in           = FSM_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_in.top_valid   = (count_in != '0);
               rsp_in.top_value   = (count_in != '0) ? top_next : '0;
               rsp_in.status      = status_ff;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      imm_ff    <= imm_in;
      sop_ff    <= sop_in;
      status_ff <= status_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/smalu_checker.sv
// ----------------------------------------------------------------------------
// Stack machine ALU checker
// Port-level checks on the request and response channels.
// ----------------------------------------------------------------------------
module smalu_checker
   import smalu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // An empty stack reports a zero top.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.top_valid |-> rsp_data.top_value == '0)
      else $error("empty stack with non-zero top");

   // Overflow can only happen on a non-empty stack.
   a_over_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_OVER |-> rsp_data.top_valid)
      else $error("overflow reported on empty stack");

   // One request is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // No response is shown straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stack_machine_alu smalu_checker u_smalu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> dv/stack_machine_alu_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack machine ALU testbench
// Drives instruction requests into the evaluation stack and predicts every
// response with a local model of the stack. Directed tests cover the empty
// stack, wrapping arithmetic and division corners, logical operations and the
// full stack. Random instruction streams then run under varying back-pressure
// on both channels.
// ----------------------------------------------------------------------------
module stack_machine_alu_tb;
   import smalu_pkg::*;

   localparam int STACK_WORDS = DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [OP_WIDTH-1:0] OP_FIRST_UNUSED = 5'd18;
   localparam logic [OP_WIDTH-1:0] OP_LAST_UNUSED  = 5'd31;
   localparam logic [DATA_WIDTH-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [DATA_WIDTH-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_WIDTH-1:0] WORD_ALL = 32'hFFFF_FFFF;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [DATA_WIDTH-1:0] stack_words [STACK_WORDS];
   int      word_count = 0;
   int      deepest = 0;
   rsp_type pending_responses [$];
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      error_count = 0;
   int      requests_sent = 0;
   int      results_checked = 0;
   int      status_seen [4] = '{0, 0, 0, 0};

   stack_machine_alu #(.STACK_DEPTH(STACK_WORDS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   initial begin
      #5_000_000;
      $display("stack_machine_alu_tb: errors");
      $finish;
   end

   function automatic void push_word(input logic [DATA_WIDTH-1:0] value);
      stack_words[word_count] = value;
      word_count++;
      if (word_count > deepest) begin
         deepest = word_count;
      end
   endfunction

   function automatic rsp_type execute_instruction(input logic [OP_WIDTH-1:0] op,
                                                   input logic [DATA_WIDTH-1:0] imm);
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic [DATA_WIDTH-1:0] r;
      logic [DATA_WIDTH-1:0] mag_a;
      logic [DATA_WIDTH-1:0] mag_b;
      logic                  produce;
      rsp_type               result;
      status_type            st;
      st = ST_OK;
      case (op)
         OP_PUSH: begin
            if (word_count >= STACK_WORDS) st = ST_OVER;
            else push_word(imm);
         end
         OP_POP: begin
            if (word_count == 0) st = ST_UNDER;
            else word_count--;
         end
         OP_COPY: begin
            if (word_count == 0) st = ST_UNDER;
            else if (word_count >= STACK_WORDS) st = ST_OVER;
            else push_word(stack_words[word_count-1]);
         end
         OP_PRINT: begin
            if (word_count == 0) st = ST_UNDER;
         end
         OP_NOT: begin
            if (word_count == 0) begin
               st = ST_UNDER;
            end else begin
               word_count--;
               a = stack_words[word_count];
               if (a == 0) push_word(32'd1);
               else if (a == 1) push_word(32'd0);
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_QUOT, OP_REM, OP_AND, OP_OR,
         OP_NE, OP_LE, OP_GE, OP_LT, OP_GT, OP_EQ: begin
            if (word_count < 2) begin
               st = ST_UNDER;
            end else begin
               b = stack_words[word_count-1];
               a = stack_words[word_count-2];
               word_count -= 2;
               produce = 1'b1;
               r = '0;
               mag_a = a[DATA_WIDTH-1] ? -a : a;
               mag_b = b[DATA_WIDTH-1] ? -b : b;
               case (op)
                  OP_ADD: r = a + b;
                  OP_SUB: r = a - b;
                  OP_MUL: r = a * b;
                  OP_QUOT, OP_REM: begin
                     if (b == 0) begin
                        st = ST_DIV0;
                        produce = 1'b0;
                     end else if (op == OP_QUOT) begin
                        r = mag_a / mag_b;
                        if (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) r = -r;
                     end else begin
                        r = mag_a % mag_b;
                        if (a[DATA_WIDTH-1]) r = -r;
                     end
                  end
                  OP_AND: r = (a == 1 && b == 1) ? 32'd1 : 32'd0;
                  OP_OR:  r = (a == 1 || b == 1) ? 32'd1 : 32'd0;
                  OP_NE:  r = (a != b) ? 32'd1 : 32'd0;
                  OP_LE:  r = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
                  OP_GE:  r = ($signed(a) >= $signed(b)) ? 32'd1 : 32'd0;
                  OP_LT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                  OP_GT:  r = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
                  default: r = (a == b) ? 32'd1 : 32'd0;
               endcase
               if (produce) push_word(r);
            end
         end
         default: ;
      endcase
      result.top_value = (word_count > 0) ? stack_words[word_count-1] : '0;
      result.top_valid = (word_count > 0);
      result.status = st;
      return result;
   endfunction

   task automatic send_request(input logic [OP_WIDTH-1:0] op,
                               input logic [DATA_WIDTH-1:0] imm);
      int      gap;
      req_type item;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.op = op;
      item.imm = imm;
      req_valid <= 1'b1;
      req_data <= item;
      pending_responses.push_back(execute_instruction(op, imm));
      requests_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            $error("response received with no request outstanding");
            error_count++;
         end else begin
            want = pending_responses.pop_front();
            results_checked++;
            status_seen[rsp_data.status]++;
            if (rsp_data.top_value !== want.top_value) begin
               $error("top_value expected %0d actual %0d", want.top_value, rsp_data.top_value);
               error_count++;
            end
            if (rsp_data.top_valid !== want.top_valid) begin
               $error("top_valid expected %0d actual %0d", want.top_valid, rsp_data.top_valid);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   function automatic logic [DATA_WIDTH-1:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'd1;
         2: return WORD_ALL;
         3: return WORD_MIN;
         4: return WORD_MAX;
         5: return $urandom_range(15);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_WIDTH-1:0] pick_binary_op();
      case ($urandom_range(12))
         0: return OP_ADD;
         1: return OP_SUB;
         2: return OP_MUL;
         3: return OP_QUOT;
         4: return OP_REM;
         5: return OP_AND;
         6: return OP_OR;
         7: return OP_NE;
         8: return OP_LE;
         9: return OP_GE;
         10: return OP_LT;
         11: return OP_GT;
         default: return OP_EQ;
      endcase
   endfunction

   task automatic test_empty_stack();
      send_request(OP_POP, $urandom());
      send_request(OP_COPY, $urandom());
      send_request(OP_PRINT, $urandom());
      send_request(OP_NOT, $urandom());
      send_request(OP_EQ, $urandom());
   endtask

   task automatic test_arithmetic_corners();
      send_request(OP_PUSH, WORD_MAX);
      send_request(OP_PUSH, 32'd1);
      send_request(OP_ADD, '0);
      send_request(OP_PUSH, WORD_ALL);
      send_request(OP_QUOT, WORD_ALL);
      send_request(OP_PUSH, WORD_ALL);
      send_request(OP_REM, '0);
      send_request(OP_NOT, '0);
      send_request(OP_PUSH, 32'd0);
      send_request(OP_QUOT, '0);
      send_request(OP_PUSH, -32'sd7);
      send_request(OP_PUSH, 32'd2);
      send_request(OP_REM, '0);
      send_request(OP_PUSH, 32'd3);
      send_request(OP_MUL, '0);
      send_request(OP_COPY, '0);
      send_request(OP_SUB, '0);
   endtask

   task automatic test_logic_ops();
      send_request(OP_NOT, '0);
      send_request(OP_COPY, '0);
      send_request(OP_AND, '0);
      send_request(OP_PUSH, 32'd0);
      send_request(OP_OR, '0);
      send_request(OP_PUSH, 32'd2);
      send_request(OP_NOT, '0);
      send_request(OP_PRINT, WORD_ALL);
      send_request(OP_LAST_UNUSED, WORD_ALL);
      send_request(OP_POP, '0);
   endtask

   task automatic test_stack_limits();
      while (word_count < STACK_WORDS) begin
         if (word_count > 0 && $urandom_range(3) == 0) send_request(OP_COPY, $urandom());
         else send_request(OP_PUSH, pick_operand());
      end
      send_request(OP_PUSH, pick_operand());
      send_request(OP_COPY, $urandom());
      send_request(OP_PRINT, $urandom());
      while (word_count > 0) begin
         if ($urandom_range(4) == 0) send_request(OP_POP, $urandom());
         else send_request(pick_binary_op(), $urandom());
      end
   endtask

   task automatic test_random_program(input int count);
      int                    pick;
      logic [OP_WIDTH-1:0]   op;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 3) op = OP_WIDTH'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
         else if (pick < 8) op = OP_WIDTH'($urandom_range(OP_EQ, OP_PUSH));
         else if (word_count < 2) op = OP_PUSH;
         else if (word_count >= STACK_WORDS - 4) op = pick_binary_op();
         else if (pick < 48) op = OP_PUSH;
         else if (pick < 53) op = OP_POP;
         else if (pick < 58) op = OP_COPY;
         else if (pick < 63) op = OP_PRINT;
         else if (pick < 68) op = OP_NOT;
         else op = pick_binary_op();
         send_request(op, (op == OP_PUSH) ? pick_operand() : $urandom());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 18;
      recv_idle_pct = 47;
      test_empty_stack();
      test_arithmetic_corners();
      test_logic_ops();
      test_stack_limits();
      test_random_program(120);
      wait_until_idle();

      send_idle_pct = 47;
      recv_idle_pct = 18;
      test_random_program(150);
      wait_until_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_program(150);
      wait_until_idle();

      $display("Sent %0d requests under three back-pressure mixes, stack depth reaching %0d.",
               requests_sent, deepest);
      $display("Checked %0d responses: %0d underflow, %0d overflow, %0d divide by zero.",
               results_checked, status_seen[ST_UNDER], status_seen[ST_OVER],
               status_seen[ST_DIV0]);
      if (error_count == 0) begin
         $display("stack_machine_alu_tb: clean");
      end else begin
         $display("stack_machine_alu_tb: errors");
      end
      $finish;
   end

endmodule

>>> sim.f
src/smalu_pkg.sv
src/smalu_cell.sv
src/smalu_div.sv
src/stack_machine_alu.sv
src/smalu_checker.sv
dv/stack_machine_alu_tb.sv
